@@ design/cfla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfla_pkg
// Shared types and constants of the chunk free-list allocator.
// ----------------------------------------------------------------------------
package cfla_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned NUM_W    = 8;

  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 16'd8;
  localparam logic [NUM_W-1:0]   BLOCK_COUNT_RST = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_REINIT  = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } cfla_op_e;

  typedef enum logic {
    REG_BLOCK_BYTES = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } cfla_reg_e;

  typedef struct packed {
    logic                start;
    logic [OFFSET_W-1:0] dividend;
    logic [BYTES_W-1:0]  divisor;
  } cfla_div_req_t;

  typedef struct packed {
    logic                done;
    logic [OFFSET_W-1:0] quotient;
  } cfla_div_rsp_t;

endpackage
`default_nettype wire

@@ design/chunk_free_list_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_free_list_allocator
// Fixed-block chunk allocator with a free list embedded in a link store.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; s_axis_tready is high only while the
// sequencer is idle. An allocate presents its result after one link store
// read and one result stage. A release presents its result once the
// bit-serial divider has turned the byte offset into a block number, 24
// quotient bits at one per cycle. A reinitialize writes one link per cycle
// for each block of the effective block count before its result. A failed
// allocate, a zero block size or an unknown operation goes straight to the
// result stage. A stalled result stream holds the result stage. A finished
// result sits in the output register while the next transaction is accepted.
// The link store is not cleared at reset; the chunk reads as full until the
// first reinitialize. Configuration writes are always taken and must only
// occur while no transaction is outstanding.
// ----------------------------------------------------------------------------
module chunk_free_list_allocator #(
  parameter int unsigned MAX_BLOCKS = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] release_offset
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [23:0] block_offset, [31:24] block_number,
                                      // [39:32] free_left
  output logic        m_axis_tuser    // [0] ok
);
  import cfla_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam logic [NUM_W-1:0] MaxBlk = NUM_W'(MAX_BLOCKS);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REINIT = 5'b00010,
    ST_ALLOC  = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } cfla_state_e;

  cfla_state_e         state_q, state_d;
  logic [BYTES_W-1:0]  block_bytes_q, block_bytes_d;
  logic [NUM_W-1:0]    block_count_q, block_count_d;
  logic [NUM_W-1:0]    head_q, head_d;
  logic [NUM_W-1:0]    count_q, count_d;
  logic [NUM_W-1:0]    cnt_q, cnt_d;
  logic [OFFSET_W-1:0] prod_q, prod_d;
  logic                res_ok_q, res_ok_d;
  logic [OFFSET_W-1:0] res_off_q, res_off_d;
  logic [NUM_W-1:0]    res_num_q, res_num_d;
  logic                out_valid_q, out_valid_d;
  logic                out_ok_q, out_ok_d;
  logic [OFFSET_W-1:0] out_off_q, out_off_d;
  logic [NUM_W-1:0]    out_num_q, out_num_d;
  logic [NUM_W-1:0]    out_free_q, out_free_d;

  logic [NUM_W-1:0]    total;
  logic                in_fire;
  logic                out_free;
  cfla_op_e            op;
  cfla_div_req_t       div_req;
  cfla_div_rsp_t       div_rsp;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [NUM_W-1:0]    mem_wdata;
  logic                mem_re;
  logic [NUM_W-1:0]    mem_rdata;

  assign total    = (block_count_q > MaxBlk) ? MaxBlk : block_count_q;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign op       = cfla_op_e'(s_axis_tuser);

  assign div_req.start    = in_fire && (op == OP_RELEASE) && (block_bytes_q != '0);
  assign div_req.dividend = s_axis_tdata;
  assign div_req.divisor  = block_bytes_q;

  cfla_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  cfla_link_mem #(
    .DEPTH (MAX_BLOCKS),
    .AW    (AW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    block_bytes_d = block_bytes_q;
    block_count_d = block_count_q;
    if (cfg_valid_i) begin
      case (cfla_reg_e'(cfg_index_i))
        REG_BLOCK_BYTES: block_bytes_d = cfg_data_i;
        REG_BLOCK_COUNT: block_count_d = cfg_data_i[NUM_W-1:0];
        default:         block_bytes_d = block_bytes_q;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    cnt_d     = cnt_q;
    prod_d    = prod_q;
    res_ok_d  = res_ok_q;
    res_off_d = res_off_q;
    res_num_d = res_num_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = cnt_q + 1'b1;
    mem_re    = 1'b0;

    out_valid_d = out_valid_q && !m_axis_tready;
    out_ok_d    = out_ok_q;
    out_off_d   = out_off_q;
    out_num_d   = out_num_q;
    out_free_d  = out_free_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_ok_d  = 1'b0;
          res_off_d = '0;
          res_num_d = '0;
          state_d   = ST_DONE;
          case (op)
            OP_REINIT: begin
              cnt_d   = '0;
              state_d = ST_REINIT;
            end
            OP_ALLOC: begin
              if (count_q != '0 && head_q < total) begin
                mem_re  = 1'b1;
                prod_d  = {16'b0, head_q} * {8'b0, block_bytes_q};
                state_d = ST_ALLOC;
              end
            end
            OP_RELEASE: begin
              if (block_bytes_q != '0) begin
                state_d = ST_DIV;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_REINIT: begin
        if (cnt_q == total) begin
          head_d   = '0;
          count_d  = total;
          res_ok_d = 1'b1;
          state_d  = ST_DONE;
        end else begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      ST_ALLOC: begin
        head_d    = mem_rdata;
        count_d   = count_q - 1'b1;
        res_ok_d  = 1'b1;
        res_off_d = prod_q;
        res_num_d = head_q;
        state_d   = ST_DONE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient < {16'b0, total}) begin
            mem_we    = 1'b1;
            mem_waddr = div_rsp.quotient[AW-1:0];
            mem_wdata = head_q;
            head_d    = div_rsp.quotient[NUM_W-1:0];
            if (count_q != '1) begin
              count_d = count_q + 1'b1;
            end
            res_ok_d  = 1'b1;
            res_num_d = div_rsp.quotient[NUM_W-1:0];
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_off_d   = res_off_q;
          out_num_d   = res_num_q;
          out_free_d  = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      block_bytes_q <= BLOCK_BYTES_RST;
      block_count_q <= BLOCK_COUNT_RST;
      head_q        <= '0;
      count_q       <= '0;
      cnt_q         <= '0;
      prod_q        <= '0;
      res_ok_q      <= 1'b0;
      res_off_q     <= '0;
      res_num_q     <= '0;
      out_valid_q   <= 1'b0;
      out_ok_q      <= 1'b0;
      out_off_q     <= '0;
      out_num_q     <= '0;
      out_free_q    <= '0;
    end else begin
      state_q       <= state_d;
      block_bytes_q <= block_bytes_d;
      block_count_q <= block_count_d;
      head_q        <= head_d;
      count_q       <= count_d;
      cnt_q         <= cnt_d;
      prod_q        <= prod_d;
      res_ok_q      <= res_ok_d;
      res_off_q     <= res_off_d;
      res_num_q     <= res_num_d;
      out_valid_q   <= out_valid_d;
      out_ok_q      <= out_ok_d;
      out_off_q     <= out_off_d;
      out_num_q     <= out_num_d;
      out_free_q    <= out_free_d;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_free_q, out_num_q, out_off_q};
  assign m_axis_tuser  = out_ok_q;

endmodule
`default_nettype wire

@@ design/cfla_link_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfla_link_mem
// Link store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cfla_link_mem #(
  parameter int unsigned DEPTH = 255,
  parameter int unsigned AW    = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [cfla_pkg::NUM_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [cfla_pkg::NUM_W-1:0] rdata_o
);
  import cfla_pkg::*;

  logic [NUM_W-1:0] mem_q [DEPTH];
  logic [NUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ design/cfla_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfla_divider
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module cfla_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfla_pkg::cfla_div_req_t req_i,
  output cfla_pkg::cfla_div_rsp_t rsp_o
);
  import cfla_pkg::*;

  localparam int unsigned STEP_W = $clog2(OFFSET_W);
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(OFFSET_W - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [BYTES_W-1:0]  rem_q, rem_d;
  logic [OFFSET_W-1:0] quo_q, quo_d;
  logic [BYTES_W-1:0]  div_q, div_d;
  logic [BYTES_W:0]    trial;
  logic [BYTES_W:0]    diff;
  logic                ge;

  assign trial = {rem_q, quo_q[OFFSET_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? diff[BYTES_W-1:0] : trial[BYTES_W-1:0];
      quo_d  = {quo_q[OFFSET_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      div_q  <= div_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

@@ design/cfla_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfla_checker
// Port-level checks of the chunk free-list allocator, bound to the top level.
// ----------------------------------------------------------------------------
module cfla_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // one transaction in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // failed result carries no offset and no block number
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
    else $error("failed result with nonzero offset or number");

endmodule

bind chunk_free_list_allocator cfla_checker u_cfla_checker (.*);
`default_nettype wire
